FILE: design/sbps_pkg.sv
// ----------------------------------------------------------------------------
// sbps_pkg
// Shared constants, register map and payload types of the byte pattern search.
// ----------------------------------------------------------------------------
package sbps_pkg;

    // Search geometry
    localparam int MAX_PATTERN = 32;
    localparam int OFFSET_BITS = 32;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 6;
    localparam int OUT_OFF_W   = 32;

    // Configuration port
    localparam int DATA_W   = 64;
    localparam int ADDR_W   = 6;
    localparam int PAT_REGS = (MAX_PATTERN * 8) / DATA_W;

    // Register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_LEN   = 3'd0;
    localparam logic [2:0] REG_PAT0  = 3'd1;
    localparam logic [2:0] REG_PAT1  = 3'd2;
    localparam logic [2:0] REG_PAT2  = 3'd3;
    localparam logic [2:0] REG_PAT3  = 3'd4;

    // Input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic                 found;
        logic [OUT_OFF_W-1:0] match_offset;
    } t_out_item;

    // Compare setup derived from the configuration registers
    typedef struct packed {
        logic [LEN_W-1:0]                len;
        logic [MAX_PATTERN-1:0]          mask;
        logic [MAX_PATTERN-1:0][7:0]     tgt;
    } t_match_cfg;

endpackage

FILE: design/sbps_cfg.sv
// ----------------------------------------------------------------------------
// sbps_cfg
// APB register file and the registered compare setup: the pattern bytes
// rearranged so that target byte k lines up with the byte k positions back.
// ----------------------------------------------------------------------------
module sbps_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [sbps_pkg::ADDR_W-1:0] paddr,
    input  logic [sbps_pkg::DATA_W-1:0] pwdata,
    output logic [sbps_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output sbps_pkg::t_match_cfg      o_match_cfg
);
    import sbps_pkg::*;

    logic [LEN_W-1:0]                 r_len;
    logic [PAT_REGS-1:0][DATA_W-1:0]  r_pat;
    t_match_cfg                       r_tgt;
    t_match_cfg                       n_tgt;
    logic [MAX_PATTERN-1:0][7:0]      pat_b;
    logic [LEN_W-1:0]                 eff_len;
    logic [2:0]                       reg_idx;
    logic                             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pat_b   = r_pat;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
            r_pat <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LEN:  r_len    <= pwdata[LEN_W-1:0];
                REG_PAT0: r_pat[0] <= pwdata;
                REG_PAT1: r_pat[1] <= pwdata;
                REG_PAT2: r_pat[2] <= pwdata;
                REG_PAT3: r_pat[3] <= pwdata;
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            REG_LEN:  prdata = {{(DATA_W-LEN_W){1'b0}}, r_len};
            REG_PAT0: prdata = r_pat[0];
            REG_PAT1: prdata = r_pat[1];
            REG_PAT2: prdata = r_pat[2];
            REG_PAT3: prdata = r_pat[3];
            default:  prdata = '0;
        endcase
    end

    // Effective length: zero acts as one, clipped to the window
    always_comb begin
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN)) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = r_len;
        end
    end

    // Target byte k = pattern byte (len-1-k); newest window byte meets the last
    always_comb begin
        int j;
        j = 0;
        n_tgt.len = eff_len;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            j = int'(eff_len) - 1 - k;
            n_tgt.mask[k] = (k < int'(eff_len));
            n_tgt.tgt[k]  = n_tgt.mask[k] ? pat_b[j[IDX_W-1:0]] : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt.len  <= LEN_W'(1);
            r_tgt.mask <= MAX_PATTERN'(1);
            r_tgt.tgt  <= '0;
        end else begin
            r_tgt <= n_tgt;
        end
    end

    assign o_match_cfg = r_tgt;

    // Effective length always lies in 1..MAX_PATTERN
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tgt.len != '0) && (r_tgt.len <= LEN_W'(MAX_PATTERN)))
        else $error("compare length out of range");

    // Mask has exactly len bits set
    a_mask_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_tgt.mask) == int'(r_tgt.len))
        else $error("compare mask does not match length");

endmodule

FILE: design/sbps_core.sv
// ----------------------------------------------------------------------------
// sbps_core
// Input register, sliding window with saturating byte count, parallel window
// compare and result register.
// ----------------------------------------------------------------------------
module sbps_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sbps_pkg::t_match_cfg i_match_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sbps_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sbps_pkg::t_out_item  o_out_data
);
    import sbps_pkg::*;

    logic                          r_in_valid;
    t_in_item                      r_in;
    logic [MAX_PATTERN-1:0][7:0]   r_win;
    logic [MAX_PATTERN-1:0][7:0]   n_win;
    logic [OFFSET_BITS-1:0]        r_count;
    logic [OFFSET_BITS-1:0]        n_count;
    logic [OFFSET_BITS-1:0]        cnt_inc;
    logic [OFFSET_BITS-1:0]        diff;
    logic                          r_hit;
    logic                          n_hit;
    logic                          r_out_valid;
    t_out_item                     r_out;
    t_out_item                     n_out;
    logic                          n_emit;
    logic                          advance;
    logic                          win_eq;
    logic [MAX_PATTERN-1:0]        byte_ok;

    // Flow control: the item in the input register moves when the result slot frees
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Shifted window and saturating count
    always_comb begin
        n_win[0] = r_in.data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_win[k] = r_win[k-1];
        end
        cnt_inc = (r_count == '1) ? r_count : r_count + OFFSET_BITS'(1);
        diff    = cnt_inc - OFFSET_BITS'(i_match_cfg.len);
    end

    // Parallel compare of the newest len bytes
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            byte_ok[k] = !i_match_cfg.mask[k] || (n_win[k] == i_match_cfg.tgt[k]);
        end
        win_eq = (&byte_ok) && (cnt_inc >= OFFSET_BITS'(i_match_cfg.len));
    end

    // Per-item decision
    always_comb begin
        n_count            = r_count;
        n_hit              = r_hit;
        n_emit             = 1'b0;
        n_out.found        = 1'b0;
        n_out.match_offset = '0;
        if (r_hit) begin
            if (r_in.end_of_stream) begin
                n_count = '0;
                n_hit   = 1'b0;
            end
        end else begin
            n_count = cnt_inc;
            if (win_eq) begin
                n_emit             = 1'b1;
                n_out.found        = 1'b1;
                n_out.match_offset = OUT_OFF_W'(diff);
                n_hit              = 1'b1;
            end else if (r_in.end_of_stream) begin
                n_emit = 1'b1;
            end
            if (r_in.end_of_stream) begin
                n_count = '0;
                n_hit   = 1'b0;
            end
        end
    end

    // Stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hit   <= 1'b0;
        end else if (advance) begin
            r_count <= n_count;
            r_hit   <= n_hit;
        end
        if (advance && !r_hit) begin
            r_win <= n_win;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A pending hit implies at least one byte was counted
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> (r_count != '0))
        else $error("hit flag set with empty byte count");

    // Not-found results carry a zero offset
    a_nf_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.found) |-> (r_out.match_offset == '0))
        else $error("not-found result with nonzero offset");

    // Stream state holds while a result waits
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> ($stable(r_count) && $stable(r_hit)))
        else $error("stream state moved during output stall");

endmodule

FILE: design/stream_byte_pattern_search_top.sv
// ----------------------------------------------------------------------------
// stream_byte_pattern_search_top
// Streaming byte pattern search: reports the first offset of a configured
// pattern of 1 to 32 bytes, or not-found at end of stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one byte per
//   transfer with an end-of-stream flag. Output channel (o_out_valid /
//   i_out_ready / o_out_data) carries at most one result per stream: found
//   with the offset of the first matched byte, or not-found (offset 0) when
//   the final byte arrives without a match. Bytes after a hit are dropped.
//   Throughput is one byte per cycle while the receiver is ready, set by the
//   combinational window compare between the input register and the result
//   register. An accepted byte is held in the input register, and its result
//   in the result register that drives o_out_valid until i_out_ready takes it.
//   When the receiver stalls, the result register holds and the input
//   register absorbs one more byte; o_in_ready then drops until the result
//   transfers. Ready never depends on the input valid.
//   Reset clears the byte count, hit flag and valid flags; pattern length
//   returns to 1 and pattern bytes to 0. Registers sit at 8-byte APB spacing;
//   the user must write them only while no stream is in flight (not enforced).
// ----------------------------------------------------------------------------
module stream_byte_pattern_search_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sbps_pkg::ADDR_W-1:0] paddr,
    input  logic [sbps_pkg::DATA_W-1:0] pwdata,
    output logic [sbps_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  sbps_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output sbps_pkg::t_out_item         o_out_data
);
    import sbps_pkg::*;

    t_match_cfg match_cfg;

    // Register file and compare setup
    sbps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_match_cfg (match_cfg)
    );

    // Search datapath
    sbps_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_match_cfg (match_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming byte pattern search. Pattern settings
// are written and read back over APB between phases. Each phase feeds streams
// built around the current pattern: full copies, copies cut short by the end
// mark, copies with one damaged byte, and plain noise. A scoreboard predicts
// every result from the accepted bytes and checks the output channel
// field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sbps_pkg::*;

    // Bench constants
    localparam longint unsigned COUNT_MAX   = ((64'd1 << (OFFSET_BITS - 1)) * 2) - 1;
    localparam logic [2:0]      REG_UNUSED  = 3'd5;   // decodes to no register
    localparam int              ITEM_GOAL   = 1150;
    localparam int              PHASE_BYTES = 100;
    localparam int              IDLE_PCT    = 29;

    typedef enum {SHAPE_PLANT, SHAPE_CUT, SHAPE_BROKEN, SHAPE_NOISE} t_stream_shape;
    typedef enum {FILL_ONES, FILL_ZEROS, FILL_TWO_SYMBOL, FILL_RANDOM} t_pattern_fill;

    // ------------------------------------------------------------------------
    // Search predictor and result checker
    // ------------------------------------------------------------------------
    class search_scoreboard;
        t_out_item        results_due[$];
        logic [7:0]       pattern_bytes[MAX_PATTERN];
        logic [LEN_W-1:0] len_reg;
        logic [7:0]       window[MAX_PATTERN];
        longint unsigned  seen;
        bit               hit_done;
        int               errors;
        int               streams;
        int               hits;
        int               misses;
        int               bytes_in;
        int               bytes_dropped;

        function new();
            foreach (pattern_bytes[i]) pattern_bytes[i] = 8'h00;
            len_reg = 1;
            clear_stream();
        endfunction

        function void clear_stream();
            foreach (window[i]) window[i] = 8'h00;
            seen     = 0;
            hit_done = 1'b0;
        endfunction

        // Zero length acts as one, over-long lengths clamp to the window
        function int unsigned eff_len();
            int unsigned n;
            n = len_reg;
            if (n == 0) n = 1;
            if (n > MAX_PATTERN) n = MAX_PATTERN;
            return n;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] value);
            int base;
            if (idx == REG_LEN) begin
                len_reg = value[LEN_W-1:0];
            end else if (idx >= REG_PAT0 && idx <= REG_PAT3) begin
                base = (idx - REG_PAT0) * 8;
                for (int k = 0; k < 8; k++) pattern_bytes[base + k] = value[8*k +: 8];
            end
        endfunction

        function logic [63:0] reg_value(logic [2:0] idx);
            logic [63:0] v;
            int          base;
            v = '0;
            if (idx == REG_LEN) begin
                v[LEN_W-1:0] = len_reg;
            end else if (idx >= REG_PAT0 && idx <= REG_PAT3) begin
                base = (idx - REG_PAT0) * 8;
                for (int k = 0; k < 8; k++) v[8*k +: 8] = pattern_bytes[base + k];
            end
            return v;
        endfunction

        // One accepted byte: slide the window and compare its newest bytes
        function void note_input(t_in_item item);
            int unsigned n;
            bit          match;
            if (item.end_of_stream) streams++;
            if (hit_done) begin
                bytes_dropped++;
                if (item.end_of_stream) clear_stream();
                return;
            end
            bytes_in++;
            for (int i = 0; i < MAX_PATTERN - 1; i++) window[i] = window[i + 1];
            window[MAX_PATTERN - 1] = item.data_byte;
            if (seen < COUNT_MAX) seen++;
            n     = eff_len();
            match = (seen >= n);
            for (int i = 0; i < n; i++)
                if (window[MAX_PATTERN - n + i] != pattern_bytes[i]) match = 1'b0;
            if (match) begin
                results_due.push_back(t_out_item'{found: 1'b1,
                                                  match_offset: OUT_OFF_W'(seen - n)});
                hits++;
                hit_done = 1'b1;
                if (item.end_of_stream) clear_stream();
            end else if (item.end_of_stream) begin
                results_due.push_back(t_out_item'{found: 1'b0, match_offset: '0});
                misses++;
                clear_stream();
            end
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (results_due.size() == 0) begin
                report($sformatf("result with nothing due: found=%0d offset=%0d",
                                 got.found, got.match_offset));
                return;
            end
            want = results_due.pop_front();
            if (got.found !== want.found)
                report($sformatf("found: got %0d, want %0d", got.found, want.found));
            if (got.match_offset !== want.match_offset)
                report($sformatf("match_offset: got %0d, want %0d",
                                 got.match_offset, want.match_offset));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_data;

    search_scoreboard  sb = new();
    int                idle_pct = IDLE_PCT;
    int                settings_done = 0;

    stream_byte_pattern_search_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stalls at random
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Monitor: check results first, then note the accepted byte
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
            if (i_in_valid && o_in_ready) sb.note_input(i_in_data);
        end
    end

    // ------------------------------------------------------------------------
    // APB access
    // ------------------------------------------------------------------------
    function automatic logic [ADDR_W-1:0] reg_addr(logic [2:0] idx);
        return {idx, 3'b000};
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic read_check(logic [2:0] idx);
        logic [63:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(idx);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== sb.reg_value(idx))
            sb.report($sformatf("register %0d read 0x%h, want 0x%h",
                                idx, got, sb.reg_value(idx)));
    endtask

    // ------------------------------------------------------------------------
    // Stream side
    // ------------------------------------------------------------------------
    // One transfer, with a random gap in front
    task automatic send_byte(logic [7:0] b, logic eos);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= t_in_item'{data_byte: b, end_of_stream: eos};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Hold the sender until every predicted result has come out
    task automatic hold_until_drained(int extra);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    // Mostly pattern bytes, so partial matches are common
    function automatic logic [7:0] filler(int n);
        if ($urandom_range(0, 9) < 7) return sb.pattern_bytes[$urandom_range(0, n - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic run_stream(t_stream_shape shape, bit pause_mid);
        logic [7:0] q[$];
        int         n;
        int         cut;
        int         flip;
        n = sb.eff_len();
        if (shape == SHAPE_NOISE) begin
            repeat ($urandom_range(1, 40)) q.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 20)) q.push_back(filler(n));
            if (shape == SHAPE_CUT) begin
                cut = $urandom_range(0, n - 1);
                for (int i = 0; i < cut; i++) q.push_back(sb.pattern_bytes[i]);
            end else begin
                flip = (shape == SHAPE_BROKEN) ? $urandom_range(0, n - 1) : -1;
                for (int i = 0; i < n; i++)
                    q.push_back(sb.pattern_bytes[i] ^
                                ((i == flip) ? 8'($urandom_range(1, 255)) : 8'h00));
                repeat ($urandom_range(0, 8)) q.push_back(filler(n));
            end
        end
        if (q.size() == 0) q.push_back(filler(n));
        for (int i = 0; i < q.size(); i++) begin
            if (pause_mid && i == q.size() / 2) hold_until_drained(0);
            send_byte(q[i], i == q.size() - 1);
        end
    endtask

    // New length and pattern; lengths cover zero, one, full and over-long
    task automatic apply_setting(int k);
        logic [63:0]   len_word;
        logic [63:0]   pat_word;
        logic [7:0]    sym[2];
        int            len_val;
        t_pattern_fill fill;
        case (k)
            0:       len_val = 63;
            1:       len_val = MAX_PATTERN;
            2:       len_val = 1;
            3:       len_val = 0;
            default: len_val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                          : $urandom_range(1, 8);
        endcase
        case (k)
            0:       fill = FILL_ONES;
            2:       fill = FILL_ZEROS;
            1:       fill = FILL_RANDOM;
            default: fill = ($urandom_range(0, 9) < 6) ? FILL_TWO_SYMBOL : FILL_RANDOM;
        endcase
        sym[0] = 8'($urandom_range(0, 255));
        sym[1] = 8'($urandom_range(0, 255));
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = LEN_W'(len_val);
        write_reg(REG_LEN, len_word);
        for (int r = REG_PAT0; r <= REG_PAT3; r++) begin
            for (int b = 0; b < 8; b++) begin
                case (fill)
                    FILL_ONES:       pat_word[8*b +: 8] = 8'hFF;
                    FILL_ZEROS:      pat_word[8*b +: 8] = 8'h00;
                    FILL_TWO_SYMBOL: pat_word[8*b +: 8] = sym[$urandom_range(0, 1)];
                    default:         pat_word[8*b +: 8] = 8'($urandom_range(0, 255));
                endcase
            end
            write_reg(3'(r), pat_word);
        end
        write_reg(REG_UNUSED, {$urandom, $urandom});
        for (int r = REG_LEN; r <= REG_PAT3; r++) read_check(3'(r));
        settings_done++;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int            phase;
        int            start;
        int            waited;
        int            pick;
        t_stream_shape shape;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: one-byte pattern 0x00
        send_byte(8'h00, 1'b1);     // match on the final byte
        send_byte(8'hFF, 1'b1);     // not found
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);     // hit at offset 1
        send_byte(8'h00, 1'b0);     // dropped after the hit
        send_byte(8'hFF, 1'b1);     // end mark after a hit: no result
        hold_until_drained(8);

        // Length zero behaves as one
        write_reg(REG_LEN, 64'd0);
        write_reg(REG_PAT0, {$urandom, 24'($urandom), 8'hA5});
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
        hold_until_drained(8);

        // Three-byte pattern FF 00 5A: short stream, then overlap in the stream
        write_reg(REG_LEN, 64'd3);
        write_reg(REG_PAT0, {$urandom, 8'($urandom), 24'h5A00FF});
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);     // stream shorter than the pattern
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b1);     // hit at offset 1 on the final byte
        hold_until_drained(8);
        settings_done += 2;

        // Random phases, one pattern setting each; every accepted byte counts
        phase = 0;
        while (sb.bytes_in + sb.bytes_dropped < ITEM_GOAL) begin
            idle_pct = (phase == 4) ? 0 : IDLE_PCT;
            apply_setting(phase);
            start = sb.bytes_in;
            while (sb.bytes_in - start < PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                if (pick < 50)      shape = SHAPE_PLANT;
                else if (pick < 65) shape = SHAPE_CUT;
                else if (pick < 80) shape = SHAPE_BROKEN;
                else                shape = SHAPE_NOISE;
                run_stream(shape, (phase == 2 && sb.bytes_in == start) ||
                                  $urandom_range(0, 9) == 0);
            end
            hold_until_drained(8);
            phase++;
        end
        idle_pct = IDLE_PCT;

        // Wait for the last results, bounded
        i_in_valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (sb.pending() != 0 && waited < 2000);
        repeat (10) @(posedge i_clk);
        while (sb.pending() != 0) begin
            sb.report($sformatf("result never came: found=%0d offset=%0d",
                                sb.results_due[0].found, sb.results_due[0].match_offset));
            void'(sb.results_due.pop_front());
        end

        $display("Run covered %0d streams (%0d hits, %0d not found) over %0d settings.",
                 sb.streams, sb.hits, sb.misses, settings_done);
        $display("Bytes searched: %0d, dropped after a hit: %0d.",
                 sb.bytes_in, sb.bytes_dropped);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
